// ===== hw/rtl/tlkf_pkg.sv =====
// tank level kalman filter: shared widths, register indexes, constants and
// divider request/response types. no dependencies.
`timescale 1ns / 1ps
package tlkf_pkg;

    localparam int LevelFracBits = 16;
    localparam int VarFracBits   = 24;
    localparam int DivDvdW       = 50;
    localparam int DivDsrW       = 26;
    localparam int MulW          = 26;
    localparam int CfgIdxW       = 3;
    localparam int CfgDataW      = 25;

    localparam logic [CfgIdxW-1:0] REG_LASER    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_HEIGHT   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_WIDTH    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_LENGTH   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MIN      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_NOISE    = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_INTERVAL = 3'd6;

    localparam logic [24:0] VAR_ONE     = 25'h1000000;
    // 17 * ceil(2^28 / 100): echo us to mm is (reading * ECHO_RECIP) >> 28
    localparam logic [25:0] ECHO_RECIP  = 26'd45634035;
    // ceil(2^40 / 125): ml from the level product is ((p >> 19) * VOL_RECIP) >> 40
    localparam logic [33:0] VOL_RECIP   = 34'd8796093023;

    typedef struct packed {
        logic               start;
        logic [DivDvdW-1:0] dividend;
        logic [DivDsrW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [DivDvdW-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== hw/rtl/tlkf_divider.sv =====
// tank level kalman filter: restoring serial divider, one quotient bit a cycle.
// depends on tlkf_pkg.
`timescale 1ns / 1ps
module tlkf_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tlkf_pkg::t_div_req i_req,
    output tlkf_pkg::t_div_rsp o_rsp
);
    import tlkf_pkg::*;

    logic [DivDvdW-1:0] r_dvd, n_dvd;
    logic [DivDsrW-1:0] r_dsr, n_dsr;
    logic [DivDsrW:0]   r_rem, n_rem;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [DivDsrW:0]   trial;

    always_comb begin
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        trial  = {r_rem[DivDsrW-1:0], r_dvd[DivDvdW-1]};
        if (i_req.start) begin
            n_dvd  = i_req.dividend;
            n_dsr  = i_req.divisor;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // quotient bits shift in where dividend bits leave
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = trial - {1'b0, r_dsr};
                n_dvd = {r_dvd[DivDvdW-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_dvd = {r_dvd[DivDvdW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(DivDvdW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_dvd;

endmodule

// ===== hw/rtl/tank_level_kalman_filter_core.sv =====
// tank level kalman filter top: config registers, sequencer, shared 26x26
// multiplier and the serial divider. depends on tlkf_pkg and tlkf_divider.
//
// channel   direction  handshake                 payload
// input     in         i_valid / o_ready         i_reading, i_timed_out
// result    out        o_valid / i_ready         o_accepted .. o_volume_ml
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one word at a time; a rejected reading goes from the check straight to the result
// register, while a kalman step passes through the serial divider for the level and
// then for the gain, the first reading and a zero variance sum skipping the gain.
// o_ready is high only while idle; the result register holds until taken.
// synchronous active-low reset restores register defaults and filter state.
`timescale 1ns / 1ps
module tank_level_kalman_filter_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [15:0]                       i_reading,
    input  logic                              i_timed_out,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic                              o_accepted,
    output logic [15:0]                       o_distance_mm,
    output logic [15:0]                       o_raw_level,
    output logic [15:0]                       o_filtered_level,
    output logic [24:0]                       o_estimate_variance,
    output logic                              o_report,
    output logic [26:0]                       o_volume_ml,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tlkf_pkg::CfgIdxW-1:0]      i_cfg_index,
    input  logic [tlkf_pkg::CfgDataW-1:0]     i_cfg_data
);
    import tlkf_pkg::*;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CONV  = 5'd1;
    localparam logic [4:0] S_CHECK = 5'd3;
    localparam logic [4:0] S_WRAW  = 5'd4;
    localparam logic [4:0] S_WK    = 5'd5;
    localparam logic [4:0] S_MULK  = 5'd6;
    localparam logic [4:0] S_UPDX  = 5'd7;
    localparam logic [4:0] S_UPDP  = 5'd8;
    localparam logic [4:0] S_CNT   = 5'd9;
    localparam logic [4:0] S_VOL1  = 5'd10;
    localparam logic [4:0] S_VOL2  = 5'd11;
    localparam logic [4:0] S_VOL3  = 5'd12;
    localparam logic [4:0] S_VOL4  = 5'd13;
    localparam logic [4:0] S_VOL5  = 5'd14;
    localparam logic [4:0] S_VOL6  = 5'd15;
    localparam logic [4:0] S_WVOL  = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;
    localparam logic [4:0] S_VOL7  = 5'd18;
    localparam logic [4:0] S_VOL8  = 5'd19;
    localparam logic [4:0] S_VOL9  = 5'd20;
    localparam logic [4:0] S_VOL10 = 5'd21;

    // config registers
    logic        r_laser;
    logic [11:0] r_height, r_width, r_length, r_min;
    logic [24:0] r_noise;
    logic [7:0]  r_interval;

    // filter state
    logic        r_started, n_started;
    logic [15:0] r_level, n_level;
    logic [24:0] r_var, n_var;
    logic [7:0]  r_count, n_count;

    // sequencer and work registers
    logic [4:0]  r_state, n_state;
    logic [15:0] r_reading, n_reading;
    logic        r_to, n_to;
    logic [15:0] r_dist, n_dist;
    logic [15:0] r_raw, n_raw;
    logic [24:0] r_k, n_k;
    logic        r_ok, n_ok;
    logic        r_rep, n_rep;
    logic [26:0] r_vol, n_vol;
    logic [51:0] r_prod, n_prod;
    logic [67:0] r_acc, n_acc;
    logic [35:0] r_hwl, n_hwl;

    logic [MulW-1:0]   mul_a, mul_b;
    logic [2*MulW-1:0] mul_p;
    logic [25:0]       var_sum;
    logic [15:0]       diff;
    logic [7:0]        cnt_inc;
    logic [51:0]       vol_sum;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    tlkf_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign var_sum = {1'b0, r_var} + {1'b0, r_noise};
    assign diff    = (r_raw >= r_level) ? (r_raw - r_level) : (r_level - r_raw);
    assign cnt_inc = r_count + 8'd1;
    assign vol_sum = r_acc[51:0] + {r_prod[33:0], 18'd0};
    assign mul_p   = mul_a * mul_b;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_CONV: begin
                mul_a = {10'd0, r_reading};
                mul_b = ECHO_RECIP;
            end
            S_MULK: begin
                mul_a = {1'b0, r_k};
                mul_b = {10'd0, diff};
            end
            S_UPDX: begin
                mul_a = {1'b0, VAR_ONE - r_k};
                mul_b = {1'b0, r_var};
            end
            S_VOL1: begin
                mul_a = {14'd0, r_height};
                mul_b = {14'd0, r_width};
            end
            S_VOL2: begin
                mul_a = {2'd0, r_prod[23:0]};
                mul_b = {14'd0, r_length};
            end
            S_VOL4: begin
                mul_a = {8'd0, r_hwl[17:0]};
                mul_b = {10'd0, r_level};
            end
            S_VOL5: begin
                mul_a = {8'd0, r_hwl[35:18]};
                mul_b = {10'd0, r_level};
            end
            // reciprocal product for the divide by 125, as four 17-bit partials
            S_VOL7: begin
                mul_a = {9'd0, r_hwl[16:0]};
                mul_b = {9'd0, VOL_RECIP[16:0]};
            end
            S_VOL8: begin
                mul_a = {9'd0, r_hwl[16:0]};
                mul_b = {9'd0, VOL_RECIP[33:17]};
            end
            S_VOL9: begin
                mul_a = {10'd0, r_hwl[32:17]};
                mul_b = {9'd0, VOL_RECIP[16:0]};
            end
            S_VOL10: begin
                mul_a = {10'd0, r_hwl[32:17]};
                mul_b = {9'd0, VOL_RECIP[33:17]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_reading = r_reading;
        n_to      = r_to;
        n_dist    = r_dist;
        n_raw     = r_raw;
        n_k       = r_k;
        n_ok      = r_ok;
        n_rep     = r_rep;
        n_vol     = r_vol;
        n_prod    = r_prod;
        n_acc     = r_acc;
        n_hwl     = r_hwl;
        n_started = r_started;
        n_level   = r_level;
        n_var     = r_var;
        n_count   = r_count;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_reading = i_reading;
                    n_to      = i_timed_out;
                    n_ok      = 1'b0;
                    n_raw     = '0;
                    n_rep     = 1'b0;
                    n_vol     = '0;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                if (r_laser) begin
                    n_dist = r_reading;
                end else begin
                    // reading*17/100 by reciprocal multiply
                    n_dist = mul_p[43:28];
                end
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!r_to && (r_dist > {4'd0, r_min}) && (r_dist < {4'd0, r_height})) begin
                    n_ok             = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.dividend = DivDvdW'({r_height - r_dist[11:0], 16'd0});
                    div_req.divisor  = {14'd0, r_height};
                    n_state          = S_WRAW;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WRAW: begin
                if (div_rsp.done) begin
                    n_raw = div_rsp.quotient[15:0];
                    if (!r_started) begin
                        n_started = 1'b1;
                        n_level   = div_rsp.quotient[15:0];
                        n_state   = S_CNT;
                    end else if (var_sum == '0) begin
                        n_k     = '0;
                        n_state = S_MULK;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DivDvdW'({r_var, 24'd0});
                        div_req.divisor  = var_sum;
                        n_state          = S_WK;
                    end
                end
            end
            S_WK: begin
                if (div_rsp.done) begin
                    n_k     = div_rsp.quotient[24:0];
                    n_state = S_MULK;
                end
            end
            S_MULK: begin
                n_prod  = mul_p;
                n_state = S_UPDX;
            end
            S_UPDX: begin
                if (r_raw >= r_level) begin
                    n_level = r_level + r_prod[39:24];
                end else begin
                    n_level = r_level - r_prod[39:24];
                end
                n_prod  = mul_p;
                n_state = S_UPDP;
            end
            S_UPDP: begin
                n_var   = r_prod[48:24];
                n_state = S_CNT;
            end
            S_CNT: begin
                if (cnt_inc >= r_interval) begin
                    n_count = '0;
                    n_rep   = 1'b1;
                    n_state = S_VOL1;
                end else begin
                    n_count = cnt_inc;
                    n_state = S_OUT;
                end
            end
            S_VOL1: begin
                n_prod  = mul_p;
                n_state = S_VOL2;
            end
            S_VOL2: begin
                n_prod  = mul_p;
                n_state = S_VOL3;
            end
            S_VOL3: begin
                n_hwl   = r_prod[35:0];
                n_state = S_VOL4;
            end
            S_VOL4: begin
                n_prod  = mul_p;
                n_state = S_VOL5;
            end
            S_VOL5: begin
                // low partial product parks while the high one is formed
                n_acc   = {16'd0, r_prod};
                n_prod  = mul_p;
                n_state = S_VOL6;
            end
            S_VOL6: begin
                // /(2^16*1000) split as >>19 then /125
                n_hwl   = {3'd0, vol_sum[51:19]};
                n_acc   = '0;
                n_state = S_VOL7;
            end
            S_VOL7: begin
                n_acc   = r_acc + {34'd0, mul_p[33:0]};
                n_state = S_VOL8;
            end
            S_VOL8: begin
                n_acc   = r_acc + {17'd0, mul_p[33:0], 17'd0};
                n_state = S_VOL9;
            end
            S_VOL9: begin
                n_acc   = r_acc + {17'd0, mul_p[33:0], 17'd0};
                n_state = S_VOL10;
            end
            S_VOL10: begin
                n_acc   = r_acc + {mul_p[33:0], 34'd0};
                n_state = S_WVOL;
            end
            S_WVOL: begin
                n_vol   = r_acc[66:40];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_started  <= 1'b0;
            r_level    <= '0;
            r_var      <= VAR_ONE;
            r_count    <= '0;
            r_laser    <= 1'b1;
            r_height   <= 12'd450;
            r_width    <= 12'd290;
            r_length   <= 12'd240;
            r_min      <= 12'd40;
            r_noise    <= 25'd16777;
            r_interval <= 8'd10;
        end else begin
            r_state   <= n_state;
            r_started <= n_started;
            r_level   <= n_level;
            r_var     <= n_var;
            r_count   <= n_count;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_LASER:    r_laser    <= i_cfg_data[0];
                    REG_HEIGHT:   r_height   <= i_cfg_data[11:0];
                    REG_WIDTH:    r_width    <= i_cfg_data[11:0];
                    REG_LENGTH:   r_length   <= i_cfg_data[11:0];
                    REG_MIN:      r_min      <= i_cfg_data[11:0];
                    REG_NOISE:    r_noise    <= i_cfg_data;
                    REG_INTERVAL: r_interval <= i_cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
        r_reading <= n_reading;
        r_to      <= n_to;
        r_dist    <= n_dist;
        r_raw     <= n_raw;
        r_k       <= n_k;
        r_ok      <= n_ok;
        r_rep     <= n_rep;
        r_vol     <= n_vol;
        r_prod    <= n_prod;
        r_acc     <= n_acc;
        r_hwl     <= n_hwl;
    end

    // no word is taken on either channel while reset is held
    assign o_ready             = (r_state == S_IDLE) && i_rst_n;
    assign o_valid             = (r_state == S_OUT);
    assign o_cfg_ready         = i_rst_n;
    assign o_accepted          = r_ok;
    assign o_distance_mm       = r_dist;
    assign o_raw_level         = r_raw;
    assign o_filtered_level    = r_level;
    assign o_estimate_variance = r_var;
    assign o_report            = r_rep;
    assign o_volume_ml         = r_vol;

    a_report_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_report |-> o_accepted)
        else $error("report on a rejected reading");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_accepted |-> (o_raw_level == 16'd0) && (o_volume_ml == 27'd0))
        else $error("rejected reading carries level or volume");

    a_var_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_UPDP |=> r_var <= $past(r_var))
        else $error("variance grew in a kalman step");

endmodule
